FILE: hdl/tcld_pkg.sv
// ----------------------------------------------------------------------------
// tcld_pkg
// Shared types, character constants and keyword tables for the text command
// line decoder.
// ----------------------------------------------------------------------------
package tcld_pkg;

   localparam int LineCap = 64;                    // bytes held per line
   localparam int AddrW   = $clog2(LineCap);
   localparam int LenW    = $clog2(LineCap + 1);

   typedef logic [7:0] char_type;

   localparam char_type CH_SPACE = 8'h20;
   localparam char_type CH_TAB   = 8'h09;
   localparam char_type CH_CR    = 8'h0D;
   localparam char_type CH_LF    = 8'h0A;
   localparam char_type CH_HASH  = "#";
   localparam char_type CH_SLASH = "/";

   typedef enum logic [3:0] {
      RSP_HELP       = 4'd0,
      RSP_LED_IS_ON  = 4'd1,
      RSP_LED_IS_OFF = 4'd2,
      RSP_LED_ON     = 4'd3,
      RSP_LED_OFF    = 4'd4,
      RSP_TOGGLED    = 4'd5,
      RSP_TOO_LONG   = 4'd6,
      RSP_BAD_ARGS   = 4'd7,
      RSP_UNKNOWN    = 4'd8
   } rsp_code_type;

   typedef enum logic [1:0] {
      ACT_NONE   = 2'd0,
      ACT_SET    = 2'd1,
      ACT_CLEAR  = 2'd2,
      ACT_TOGGLE = 2'd3
   } led_act_type;

   localparam char_type WordHelp   [4] = '{"h", "e", "l", "p"};
   localparam char_type WordStatus [6] = '{"s", "t", "a", "t", "u", "s"};
   localparam char_type WordLed    [3] = '{"l", "e", "d"};
   localparam char_type WordOn     [2] = '{"o", "n"};
   localparam char_type WordOff    [3] = '{"o", "f", "f"};
   localparam char_type WordToggle [6] = '{"t", "o", "g", "g", "l", "e"};

   function automatic char_type to_lower(input char_type c);
      char_type r;
      r = c;
      if (c >= "A" && c <= "Z") begin
         r = c + 8'd32;
      end
      return r;
   endfunction

   function automatic logic is_blank(input char_type c);
      return (c == CH_SPACE) || (c == CH_TAB);
   endfunction

   function automatic logic is_eol(input char_type c);
      return (c == CH_CR) || (c == CH_LF);
   endfunction

endpackage

FILE: hdl/tcld_if.sv
// ----------------------------------------------------------------------------
// tcld channel interfaces
// Valid/ready channels for received bytes and for decoded command results.
// ----------------------------------------------------------------------------
interface tcld_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       led_level;

   modport source (output valid, output rx_byte, output led_level, input ready);
   modport sink   (input valid, input rx_byte, input led_level, output ready);
endinterface

interface tcld_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] response;
   logic [1:0] led_action;
   logic       command_activity;

   modport source (output valid, output response, output led_action,
                   output command_activity, input ready);
   modport sink   (input valid, input response, input led_action,
                   input command_activity, output ready);
endinterface

FILE: hdl/text_command_line_decoder.sv
// ----------------------------------------------------------------------------
// text_command_line_decoder
// Assembles received bytes into command lines and decodes help, status and
// led on/off/toggle commands.
// ----------------------------------------------------------------------------
// Each byte that belongs to a line is stored into a 64-byte line buffer
// (a synchronous memory with one write and one read port) and the line
// state is updated. A CR or LF that closes a buffered line starts a walk
// over the buffer, one byte per cycle through the memory read port, and a
// finish phase then loads the result into the output register. No byte is
// taken during that walk. A line-too-long result is given on the byte that
// overflows the buffer. Empty and comment lines give no result. A result
// waits in an output register; the next byte is taken while it waits only
// if the result is taken in the same cycle.
module text_command_line_decoder (
   input  logic       clock,
   input  logic       reset,
   tcld_req_if.sink   req_chan,
   tcld_rsp_if.source rsp_chan
);
   import tcld_pkg::*;

   typedef enum logic [3:0] {
      MODE_IDLE  = 4'b0001,
      MODE_RECV  = 4'b0010,
      MODE_SKIP  = 4'b0100,
      MODE_SLASH = 4'b1000
   } mode_type;

   typedef enum logic [2:0] {
      PH_ACCEPT = 3'b001,
      PH_WALK   = 3'b010,
      PH_FINISH = 3'b100
   } phase_type;

   mode_type     mode_ff, mode_in;
   phase_type    phase_ff, phase_in;
   logic [LenW-1:0]  len_ff, len_in;
   logic             lvl_ff, lvl_in;

   char_type         line_mem [LineCap];
   logic             mem_we;
   logic [AddrW-1:0] mem_wa;
   char_type         rd_data_ff;
   logic [LenW-1:0]  rd_addr_ff, rd_addr_in;
   logic             rd_vld_ff, rd_vld_in;
   logic [AddrW-1:0] proc_idx_ff, proc_idx_in;
   logic             issue;

   logic             help_ok_ff, help_ok_in;
   logic             stat_ok_ff, stat_ok_in;
   logic             led_ok_ff, led_ok_in;
   logic             arg_seen_ff, arg_seen_in;
   logic             arg_end_ff, arg_end_in;
   logic             arg_bad_ff, arg_bad_in;
   logic [2:0]       arg_cnt_ff, arg_cnt_in;
   logic [2:0]       cand_ff, cand_in;     // {toggle, off, on}

   logic             rsp_valid_ff, rsp_valid_in;
   rsp_code_type     response_ff, response_in;
   led_act_type      action_ff, action_in;
   logic             activity_ff, activity_in;

   logic             req_xfer;
   logic             walk_start;
   logic             emit_long;
   logic             load_final;
   char_type         c;
   char_type         lc;
   logic             bl;
   logic             arg_ok_on, arg_ok_off, arg_ok_tog;
   rsp_code_type     final_rsp;
   led_act_type      final_act;
   logic             final_busy;

   assign c        = req_chan.rx_byte;
   assign req_chan.ready = (phase_ff == PH_ACCEPT) && (!rsp_valid_ff || rsp_chan.ready);
   assign req_xfer = req_chan.valid && req_chan.ready;

   // line state and byte intake
   always_comb begin
      mode_in    = mode_ff;
      phase_in   = phase_ff;
      len_in     = len_ff;
      lvl_in     = lvl_ff;
      mem_we     = 1'b0;
      mem_wa     = len_ff[AddrW-1:0];
      walk_start = 1'b0;
      emit_long  = 1'b0;
      load_final = 1'b0;
      issue      = 1'b0;
      rd_addr_in = rd_addr_ff;
      rd_vld_in  = 1'b0;
      proc_idx_in = rd_addr_ff[AddrW-1:0];

      unique case (phase_ff)
         PH_ACCEPT: begin
            if (req_xfer) begin
               unique case (mode_ff) inside
                  MODE_IDLE: begin
                     if (!is_eol(c) && !is_blank(c)) begin
                        if (c == CH_HASH) begin
                           mode_in = MODE_SKIP;
                        end else begin
                           mem_we  = 1'b1;
                           mem_wa  = '0;
                           len_in  = LenW'(1);
                           mode_in = (c == CH_SLASH) ? MODE_SLASH : MODE_RECV;
                        end
                     end
                  end
                  MODE_SLASH, MODE_RECV: begin
                     if (mode_ff == MODE_SLASH && c == CH_SLASH) begin
                        mode_in = MODE_SKIP;
                     end else if (is_eol(c)) begin
                        mode_in    = MODE_IDLE;
                        phase_in   = PH_WALK;
                        walk_start = 1'b1;
                        lvl_in     = req_chan.led_level;
                        rd_addr_in = '0;
                     end else if (len_ff < LenW'(LineCap)) begin
                        mem_we  = 1'b1;
                        len_in  = len_ff + LenW'(1);
                        mode_in = MODE_RECV;
                     end else begin
                        mode_in   = MODE_SKIP;
                        emit_long = 1'b1;
                     end
                  end
                  MODE_SKIP: begin
                     if (is_eol(c)) begin
                        mode_in = MODE_IDLE;
                     end
                  end
                  default: mode_in = MODE_IDLE;
               endcase
            end
         end
         PH_WALK: begin
            issue     = rd_addr_ff < len_ff;
            rd_vld_in = issue;
            if (issue) begin
               rd_addr_in = rd_addr_ff + LenW'(1);
            end
            if (!issue && !rd_vld_ff) begin
               phase_in = PH_FINISH;
            end
         end
         PH_FINISH: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               load_final = 1'b1;
               phase_in   = PH_ACCEPT;
            end
         end
         default: phase_in = PH_ACCEPT;
      endcase
   end

   // per-byte keyword matching on the walk
   assign lc = to_lower(rd_data_ff);
   assign bl = is_blank(rd_data_ff);

   always_comb begin
      help_ok_in  = help_ok_ff;
      stat_ok_in  = stat_ok_ff;
      led_ok_in   = led_ok_ff;
      arg_seen_in = arg_seen_ff;
      arg_end_in  = arg_end_ff;
      arg_bad_in  = arg_bad_ff;
      arg_cnt_in  = arg_cnt_ff;
      cand_in     = cand_ff;
      if (walk_start) begin
         help_ok_in  = 1'b1;
         stat_ok_in  = 1'b1;
         led_ok_in   = 1'b1;
         arg_seen_in = 1'b0;
         arg_end_in  = 1'b0;
         arg_bad_in  = 1'b0;
         arg_cnt_in  = '0;
         cand_in     = 3'b111;
      end else if (rd_vld_ff) begin
         // the keyword itself, then only trailing blanks for help and status, or one argument word for led
         if (proc_idx_ff < AddrW'(4)) begin
            if (lc != WordHelp[proc_idx_ff[1:0]]) help_ok_in = 1'b0;
         end else if (!bl) begin
            help_ok_in = 1'b0;
         end
         if (proc_idx_ff < AddrW'(6)) begin
            if (lc != WordStatus[proc_idx_ff[2:0]]) stat_ok_in = 1'b0;
         end else if (!bl) begin
            stat_ok_in = 1'b0;
         end
         if (proc_idx_ff < AddrW'(3)) begin
            if (lc != WordLed[proc_idx_ff[1:0]]) led_ok_in = 1'b0;
         end else if (bl) begin
            if (arg_seen_ff) arg_end_in = 1'b1;
         end else if (arg_end_ff) begin
            arg_bad_in = 1'b1;   // a second word after the argument
         end else begin
            arg_seen_in = 1'b1;
            if (!(arg_cnt_ff < 3'd2 && lc == WordOn[arg_cnt_ff[0]])) cand_in[0] = 1'b0;
            if (!(arg_cnt_ff < 3'd3 && lc == WordOff[arg_cnt_ff[1:0]])) cand_in[1] = 1'b0;
            if (!(arg_cnt_ff < 3'd6 && lc == WordToggle[arg_cnt_ff])) cand_in[2] = 1'b0;
            if (arg_cnt_ff != 3'd7) arg_cnt_in = arg_cnt_ff + 3'd1;
         end
      end
   end

   // verdict once the whole line has been seen
   assign arg_ok_on  = !arg_bad_ff && arg_seen_ff && cand_ff[0] && arg_cnt_ff == 3'd2;
   assign arg_ok_off = !arg_bad_ff && arg_seen_ff && cand_ff[1] && arg_cnt_ff == 3'd3;
   assign arg_ok_tog = !arg_bad_ff && arg_seen_ff && cand_ff[2] && arg_cnt_ff == 3'd6;

   always_comb begin
      final_rsp  = RSP_UNKNOWN;
      final_act  = ACT_NONE;
      final_busy = 1'b0;
      if (help_ok_ff && len_ff >= LenW'(4)) begin
         final_rsp = RSP_HELP;
      end else if (stat_ok_ff && len_ff >= LenW'(6)) begin
         final_rsp = lvl_ff ? RSP_LED_IS_ON : RSP_LED_IS_OFF;
      end else if (led_ok_ff && len_ff >= LenW'(3)) begin
         if (arg_ok_on) begin
            final_rsp  = RSP_LED_ON;
            final_act  = ACT_SET;
            final_busy = 1'b1;
         end else if (arg_ok_off) begin
            final_rsp  = RSP_LED_OFF;
            final_act  = ACT_CLEAR;
            final_busy = 1'b1;
         end else if (arg_ok_tog) begin
            final_rsp  = RSP_TOGGLED;
            final_act  = ACT_TOGGLE;
            final_busy = 1'b1;
         end else begin
            final_rsp = RSP_BAD_ARGS;
         end
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      response_in  = response_ff;
      action_in    = action_ff;
      activity_in  = activity_ff;
      if (emit_long) begin
         rsp_valid_in = 1'b1;
         response_in  = RSP_TOO_LONG;
         action_in    = ACT_NONE;
         activity_in  = 1'b0;
      end else if (load_final) begin
         rsp_valid_in = 1'b1;
         response_in  = final_rsp;
         action_in    = final_act;
         activity_in  = final_busy;
      end
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.response         = response_ff;
   assign rsp_chan.led_action       = action_ff;
   assign rsp_chan.command_activity = activity_ff;

   // line buffer
   always_ff @(posedge clock) begin
      if (mem_we) begin
         line_mem[mem_wa] <= c;
      end
      rd_data_ff <= line_mem[rd_addr_ff[AddrW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_IDLE;
         phase_ff     <= PH_ACCEPT;
         len_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         phase_ff     <= phase_in;
         len_ff       <= len_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lvl_ff      <= lvl_in;
      rd_addr_ff  <= rd_addr_in;
      proc_idx_ff <= proc_idx_in;
      help_ok_ff  <= help_ok_in;
      stat_ok_ff  <= stat_ok_in;
      led_ok_ff   <= led_ok_in;
      arg_seen_ff <= arg_seen_in;
      arg_end_ff  <= arg_end_in;
      arg_bad_ff  <= arg_bad_in;
      arg_cnt_ff  <= arg_cnt_in;
      cand_ff     <= cand_in;
      response_ff <= response_in;
      action_ff   <= action_in;
      activity_ff <= activity_in;
   end

`ifndef SYNTH
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LenW'(LineCap))
      else $error("line length beyond buffer capacity");

   a_len_stable_walk: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_WALK && $past(phase_ff == PH_WALK)) |-> $stable(len_ff))
      else $error("line length changed during buffer walk");

   a_read_in_line: assert property (@(posedge clock) disable iff (reset)
      rd_vld_ff |-> ({1'b0, proc_idx_ff} < len_ff))
      else $error("buffer read beyond line end");

   a_activity_action: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && activity_ff) |-> (action_ff != ACT_NONE))
      else $error("activity flagged without an LED action");
`endif

endmodule

FILE: bench/tb_text_command_line_decoder.sv
// ----------------------------------------------------------------------------
// tb_text_command_line_decoder
// Self-checking bench for the text command line decoder. Bytes are sent over
// the request channel as directed lines (keywords, case, blanks, comments,
// lone slash, buffer limits, odd bytes) and then as random lines and noise.
// A scoreboard predicts every reply and checks the reply channel in order
// under three back-pressure phases.
// ----------------------------------------------------------------------------
module tb_text_command_line_decoder;
   import tcld_pkg::*;

   typedef enum logic [1:0] {
      LM_IDLE  = 2'd0,
      LM_RECV  = 2'd1,
      LM_SKIP  = 2'd2,
      LM_SLASH = 2'd3
   } line_mode_type;

   typedef struct packed {
      rsp_code_type code;
      led_act_type  act;
      logic         busy;
   } reply_type;

   class command_reply_board;
      line_mode_type mode;
      char_type      held [LineCap];
      int unsigned   held_len;
      reply_type     expected_replies [$];
      int            errors;

      function new();
         mode     = LM_IDLE;
         held_len = 0;
         errors   = 0;
      endfunction

      function char_type fold(char_type c);
         return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
      endfunction

      function bit blank(char_type c);
         return (c == CH_SPACE) || (c == CH_TAB);
      endfunction

      function bit line_end(char_type c);
         return (c == CH_CR) || (c == CH_LF);
      endfunction

      function bit span_is(int s, int e, string w);
         if (e - s != w.len()) return 0;
         for (int i = 0; i < w.len(); i++) begin
            if (fold(held[s + i]) != w[i]) return 0;
         end
         return 1;
      endfunction

      function void expect_reply(rsp_code_type code, led_act_type act, logic busy);
         reply_type r;
         r.code = code;
         r.act  = act;
         r.busy = busy;
         expected_replies.push_back(r);
      endfunction

      function void close_line(logic lvl);
         int s;
         int e;
         int a;
         s = 0;
         e = held_len;
         while (s < e && blank(held[s])) s++;
         while (e > s && blank(held[e - 1])) e--;
         if (s == e) return;
         if (span_is(s, e, "help")) begin
            expect_reply(RSP_HELP, ACT_NONE, 1'b0);
         end else if (span_is(s, e, "status")) begin
            expect_reply(lvl ? RSP_LED_IS_ON : RSP_LED_IS_OFF, ACT_NONE, 1'b0);
         end else if (e - s >= 3 && span_is(s, s + 3, "led")) begin
            // argument is whatever follows the three letters, so "ledon" is valid
            a = s + 3;
            while (a < e && blank(held[a])) a++;
            if (span_is(a, e, "on"))          expect_reply(RSP_LED_ON, ACT_SET, 1'b1);
            else if (span_is(a, e, "off"))    expect_reply(RSP_LED_OFF, ACT_CLEAR, 1'b1);
            else if (span_is(a, e, "toggle")) expect_reply(RSP_TOGGLED, ACT_TOGGLE, 1'b1);
            else                              expect_reply(RSP_BAD_ARGS, ACT_NONE, 1'b0);
         end else begin
            expect_reply(RSP_UNKNOWN, ACT_NONE, 1'b0);
         end
      endfunction

      function void add_char(char_type c, logic lvl);
         if (line_end(c)) begin
            mode = LM_IDLE;
            close_line(lvl);
         end else if (held_len < LineCap) begin
            held[held_len] = c;
            held_len++;
         end else begin
            // overflow reports once, the rest of the line is dropped
            mode = LM_SKIP;
            expect_reply(RSP_TOO_LONG, ACT_NONE, 1'b0);
         end
      endfunction

      // note one accepted byte transfer
      function void take_byte(char_type c, logic lvl);
         case (mode)
            LM_IDLE: begin
               if (!line_end(c) && !blank(c)) begin
                  if (c == CH_HASH) begin
                     mode = LM_SKIP;
                  end else begin
                     held[0]  = c;
                     held_len = 1;
                     mode     = (c == CH_SLASH) ? LM_SLASH : LM_RECV;
                  end
               end
            end
            LM_SLASH: begin
               if (c == CH_SLASH) begin
                  mode = LM_SKIP;
               end else begin
                  mode = LM_RECV;
                  add_char(c, lvl);
               end
            end
            LM_RECV: begin
               add_char(c, lvl);
            end
            default: begin
               if (line_end(c)) mode = LM_IDLE;
            end
         endcase
      endfunction

      // check one accepted reply transfer against the oldest prediction
      function void check_reply(logic [3:0] code, logic [1:0] act, logic busy);
         reply_type exp_r;
         if (expected_replies.size() == 0) begin
            $display("%0t: unexpected reply response=%0d led_action=%0d activity=%0d",
                     $time, code, act, busy);
            errors++;
            return;
         end
         exp_r = expected_replies.pop_front();
         if (code !== exp_r.code) begin
            $display("%0t: response expected %0d, got %0d", $time, exp_r.code, code);
            errors++;
         end
         if (act !== exp_r.act) begin
            $display("%0t: led_action expected %0d, got %0d", $time, exp_r.act, act);
            errors++;
         end
         if (busy !== exp_r.busy) begin
            $display("%0t: command_activity expected %0d, got %0d", $time, exp_r.busy,
                     busy);
            errors++;
         end
      endfunction

      function int pending();
         return expected_replies.size();
      endfunction
   endclass

   localparam int RandomBytes = 1500;
   localparam int StallLimit  = 5000;

   logic clock;
   logic reset;
   int   send_gap_pct;
   int   take_gap_pct;
   int   bytes_sent;
   int   stall_cycles;

   command_reply_board board;

   tcld_req_if req_chan ();
   tcld_rsp_if rsp_chan ();

   text_command_line_decoder u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         board.check_reply(rsp_chan.response, rsp_chan.led_action,
                           rsp_chan.command_activity);
      end
      rsp_chan.ready <= ($urandom_range(99) >= take_gap_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) ||
          (rsp_chan.valid && rsp_chan.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= StallLimit) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic send_byte(input char_type c);
      logic lvl;
      lvl = $urandom_range(1);
      while ($urandom_range(99) < send_gap_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.rx_byte   <= c;
      req_chan.led_level <= lvl;
      do @(posedge clock); while (!req_chan.ready);
      board.take_byte(c, lvl);
      bytes_sent++;
   endtask

   task automatic send_text(input string text, input char_type term);
      for (int i = 0; i < text.len(); i++) send_byte(text[i]);
      send_byte(term);
   endtask

   function automatic string filler(int n, byte ch);
      string s;
      s = "";
      for (int i = 0; i < n; i++) s = {s, string'(ch)};
      return s;
   endfunction

   function automatic string rand_blanks(int max_n);
      string s;
      int    n;
      s = "";
      n = $urandom_range(max_n);
      for (int i = 0; i < n; i++) begin
         s = {s, string'($urandom_range(1) ? CH_SPACE : CH_TAB)};
      end
      return s;
   endfunction

   function automatic string rand_case(string w);
      string s;
      s = w;
      for (int i = 0; i < s.len(); i++) begin
         if (s[i] >= "a" && s[i] <= "z" && $urandom_range(1)) s[i] = s[i] - 8'd32;
      end
      return s;
   endfunction

   function automatic char_type rand_term();
      return $urandom_range(1) ? CH_CR : CH_LF;
   endfunction

   // printable byte that is not a line end; blanks now and then
   function automatic char_type rand_text_char();
      return ($urandom_range(7) == 0) ? CH_SPACE : char_type'($urandom_range(33, 126));
   endfunction

   task automatic send_command_line();
      string body;
      string junk [6];
      string typo [6];
      junk = '{"", "blink", "o", "onn", "toggl", "offf"};
      typo = '{"hel", "helpx", "stat", "le", "/help", "statuss"};
      case ($urandom_range(7))
         0:       body = "help";
         1:       body = "status";
         2:       body = {"led", rand_blanks(2), "on"};
         3:       body = {"led", rand_blanks(2), "off"};
         4:       body = {"led", rand_blanks(2), "toggle"};
         5:       body = {"led", rand_blanks(2), junk[$urandom_range(5)]};
         6:       body = typo[$urandom_range(5)];
         default: body = "ledtoggle";
      endcase
      send_text({rand_blanks(3), rand_case(body), rand_blanks(3)}, rand_term());
      if ($urandom_range(3) == 0) send_byte(CH_LF);
   endtask

   task automatic send_comment_line();
      int n;
      n = $urandom_range(8);
      if ($urandom_range(1)) begin
         send_byte(CH_HASH);
      end else begin
         send_byte(CH_SLASH);
         send_byte(CH_SLASH);
      end
      send_byte(CH_SPACE);
      for (int i = 0; i < n; i++) send_byte(rand_text_char());
      send_byte(rand_term());
   endtask

   task automatic send_junk_line();
      int n;
      n = $urandom_range(1, 10);
      if ($urandom_range(3) == 0) send_byte(CH_SLASH);
      for (int i = 0; i < n; i++) begin
         send_byte($urandom_range(1) ? rand_text_char() : char_type'($urandom_range(255)));
      end
      send_byte(rand_term());
   endtask

   task automatic send_long_line();
      int n;
      n = $urandom_range(LineCap - 4, LineCap + 6);
      for (int i = 0; i < n; i++) send_byte(rand_text_char());
      send_byte(rand_term());
   endtask

   initial begin
      int stop_at;
      int kind;
      board          = new();
      clock          = 1'b0;
      reset          = 1'b1;
      send_gap_pct   = 20;
      take_gap_pct   = 66;
      bytes_sent     = 0;
      req_chan.valid     <= 1'b0;
      req_chan.rx_byte   <= 8'h00;
      req_chan.led_level <= 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed lines
      send_text("help", CH_LF);
      send_text("STATUS", CH_CR);
      send_text("status", CH_LF);
      send_text("  Led On \t", CH_CR);
      send_text("led off", CH_LF);
      send_text("LED\tTOGGLE", CH_LF);
      send_text("ledon", CH_CR);
      send_text("led  ", CH_LF);
      send_text("led blink", CH_LF);
      send_text("# help", CH_LF);
      send_text("//status", CH_CR);
      send_text("/x", CH_LF);
      send_text("/", CH_CR);
      send_text("foo", CH_LF);
      send_text(" \t ", CH_CR);
      send_byte(CH_LF);
      send_text({filler(LineCap - 4, " "), "help"}, CH_LF);
      send_text({filler(LineCap + 1, "a"), "xyz"}, CH_CR);
      send_byte(CH_LF);
      send_byte("h");
      send_byte(8'h00);
      send_byte(8'hFF);
      send_text("lp", CH_LF);

      stop_at = bytes_sent + RandomBytes;
      while (bytes_sent < stop_at) begin
         if (bytes_sent > stop_at - RandomBytes / 3) begin
            send_gap_pct = 0;
            take_gap_pct = 0;
         end else if (bytes_sent > stop_at - 2 * RandomBytes / 3) begin
            send_gap_pct = 66;
            take_gap_pct = 20;
         end
         kind = $urandom_range(99);
         if (kind < 60)      send_command_line();
         else if (kind < 70) send_comment_line();
         else if (kind < 80) send_junk_line();
         else if (kind < 83) send_long_line();
         else begin
            // raw noise, line ends included
            repeat ($urandom_range(1, 8)) send_byte(char_type'($urandom_range(255)));
         end
      end
      req_chan.valid <= 1'b0;

      while (board.pending() != 0) @(posedge clock);
      repeat (LineCap + 8) @(posedge clock);
      if (board.errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
